// ===== sv/qrs_pkg.sv =====
// Package for the quadratic root solver: widths, root kind codes and a saturation helper.
package qrs_pkg;

   localparam int COEF_WIDTH_DEF = 16;
   localparam int DISC_WIDTH = 34;
   localparam int VAL_WIDTH = 32;
   localparam int KIND_WIDTH = 3;

   typedef enum logic [KIND_WIDTH-1:0] {
      KIND_DOUBLE  = 3'd0,
      KIND_TWO     = 3'd1,
      KIND_IMAG    = 3'd2,
      KIND_COMPLEX = 3'd3,
      KIND_ERROR   = 3'd4
   } root_kind_type;

   // Saturate a sign and magnitude pair to a 32-bit two's complement value.
   function automatic logic [VAL_WIDTH-1:0] sat32(input logic neg, input logic [127:0] mag);
      logic [VAL_WIDTH-1:0] r;
      if (neg) begin
         if (mag >= 128'h8000_0000) r = 32'h8000_0000;
         else r = 32'(-mag[VAL_WIDTH-1:0]);
      end else begin
         if (mag > 128'h7FFF_FFFF) r = 32'h7FFF_FFFF;
         else r = mag[VAL_WIDTH-1:0];
      end
      return r;
   endfunction

endpackage

// ===== sv/quadratic_root_solver.sv =====
// Top level of the quadratic root solver: discriminant, square root chain and divider chains.
// Throughput: one coefficient set per cycle; busy is tied low.
// Every square root and division step is one cell of a registered chain.
// Reset is synchronous and clears only the valid bits of the chain.
// The receiver cannot stall; each result shows for one cycle.
module quadratic_root_solver #(
   parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic signed [COEF_WIDTH-1:0]      req_coef_a,
   input  logic signed [COEF_WIDTH-1:0]      req_coef_b,
   input  logic signed [COEF_WIDTH-1:0]      req_coef_c,
   output logic                              rsp_valid,
   output logic signed [qrs_pkg::DISC_WIDTH-1:0] rsp_discriminant,
   output logic signed [qrs_pkg::VAL_WIDTH-1:0]  rsp_centre_value,
   output logic signed [qrs_pkg::VAL_WIDTH-1:0]  rsp_offset_value,
   output logic [qrs_pkg::KIND_WIDTH-1:0]        rsp_root_kind
);
   import qrs_pkg::*;

   localparam int CW  = COEF_WIDTH;
   localparam int DW  = 2 * CW + 3;            // |D| magnitude width
   localparam int RAD = 2 * (((DW + 30) + 1) / 2); // even radicand width
   localparam int RTW = RAD / 2;               // root width
   localparam int NSQ = RTW;                   // sqrt cells
   localparam int ONW = RTW;                   // offset numerator width
   localparam int CNW = CW + 15;               // centre numerator width

   assign busy = 1'b0;

   // Stage 1: magnitudes.
   logic          s1_v_ff;
   logic [CW-1:0] ma_ff, mb_ff, mc_ff;
   logic          sa_ff, sb_ff, sc_ff;
   always_ff @(posedge clock) begin
      if (reset) s1_v_ff <= 1'b0;
      else s1_v_ff <= start;
      sa_ff <= req_coef_a[CW-1];
      sb_ff <= req_coef_b[CW-1];
      sc_ff <= req_coef_c[CW-1];
      ma_ff <= req_coef_a[CW-1] ? CW'(-req_coef_a) : req_coef_a;
      mb_ff <= req_coef_b[CW-1] ? CW'(-req_coef_b) : req_coef_b;
      mc_ff <= req_coef_c[CW-1] ? CW'(-req_coef_c) : req_coef_c;
   end

   // Stage 2: products.
   logic            s2_v_ff, s2_sa_ff, s2_sb_ff, s2_sc_ff;
   logic [CW-1:0]   s2_ma_ff, s2_mb_ff;
   logic [2*CW-1:0] bb_ff, ac_ff;
   always_ff @(posedge clock) begin
      if (reset) s2_v_ff <= 1'b0;
      else s2_v_ff <= s1_v_ff;
      s2_sa_ff <= sa_ff;
      s2_sb_ff <= sb_ff;
      s2_sc_ff <= sc_ff;
      s2_ma_ff <= ma_ff;
      s2_mb_ff <= mb_ff;
      bb_ff    <= mb_ff * mb_ff;
      ac_ff    <= ma_ff * mc_ff;
   end

   // Stage 3: discriminant magnitude and sign.
   logic [DW-1:0] q_w, bb_w, dmag_w;
   logic          dneg_w;
   always_comb begin
      q_w  = DW'({1'b0, ac_ff, 2'b00});
      bb_w = DW'(bb_ff);
      dneg_w = 1'b0;
      if (s2_sa_ff != s2_sc_ff && ac_ff != '0) begin
         dmag_w = bb_w + q_w;
      end else if (bb_w < q_w) begin
         dmag_w = q_w - bb_w;
         dneg_w = 1'b1;
      end else begin
         dmag_w = bb_w - q_w;
      end
   end

   typedef struct packed {
      logic                 az;
      logic                 sa;
      logic                 dneg;
      logic                 dzero;
      logic                 bzero;
      logic [DISC_WIDTH-1:0] dout;
      logic [CW-1:0]        ma;
      logic [VAL_WIDTH-1:0] centre;
   } side_type;

   logic          s3_v_ff;
   side_type      s3_ff;
   logic [CNW-1:0] cnum_ff;
   logic          cneg_ff;
   logic [DISC_WIDTH-1:0] dout_w;
   always_comb begin
      if (dneg_w) begin
         if ({1'b0, dmag_w} > (DW + 1)'(64'd1 << 33)) dout_w = DISC_WIDTH'(64'd1 << 33);
         else dout_w = DISC_WIDTH'(-{1'b0, dmag_w});
      end else begin
         if ({1'b0, dmag_w} > (DW + 1)'((64'd1 << 33) - 1)) dout_w = DISC_WIDTH'((64'd1 << 33) - 1);
         else dout_w = DISC_WIDTH'(dmag_w);
      end
   end

   logic [RAD-1:0] rad0_ff;
   always_ff @(posedge clock) begin
      if (reset) s3_v_ff <= 1'b0;
      else s3_v_ff <= s2_v_ff;
      s3_ff.az     <= (s2_ma_ff == '0);
      s3_ff.sa     <= s2_sa_ff;
      s3_ff.dneg   <= dneg_w;
      s3_ff.dzero  <= (dmag_w == '0);
      s3_ff.bzero  <= (s2_mb_ff == '0);
      s3_ff.dout   <= dout_w;
      s3_ff.ma     <= s2_ma_ff;
      s3_ff.centre <= '0;
      cnum_ff      <= {s2_mb_ff, 15'd0};
      cneg_ff      <= (s2_mb_ff != '0) && (s2_sb_ff == s2_sa_ff);
      rad0_ff      <= RAD'({dmag_w, 30'd0});
   end

   // Square root chain; centre division rides alongside in its own cells.
   logic [NSQ:0] sq_v;
   logic [RAD-1:0] sq_rad [NSQ+1];
   logic [RTW:0]   sq_rem [NSQ+1];
   logic [RTW-1:0] sq_root [NSQ+1];
   side_type       sq_side_ff [NSQ];
   logic [CNW-1:0] cd_num [CNW+1];
   logic [CW-1:0]  cd_den [CNW+1];
   logic [CW:0]    cd_rem [CNW+1];
   logic [CNW:0]   cd_v;

   assign sq_v[0]    = s3_v_ff;
   assign sq_rad[0]  = rad0_ff;
   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;

   genvar g;
   for (g = 0; g < NSQ; g++) begin : g_sq
      qrs_sqrt_cell #(.RAD_WIDTH(RAD), .STEP(g)) u_cell (
         .clock(clock), .reset(reset), .valid_in(sq_v[g]),
         .rad_in(sq_rad[g]), .rem_in(sq_rem[g]), .root_in(sq_root[g]),
         .valid_out(sq_v[g+1]), .rad_out(sq_rad[g+1]),
         .rem_out(sq_rem[g+1]), .root_out(sq_root[g+1])
      );
   end

   // Centre divider: CNW cells starting at the same stage (CNW < NSQ).
   assign cd_v[0]   = s3_v_ff;
   assign cd_num[0] = cnum_ff;
   assign cd_den[0] = s3_ff.ma;
   assign cd_rem[0] = '0;
   for (g = 0; g < CNW; g++) begin : g_cd
      qrs_div_cell #(.NUM_WIDTH(CNW), .DEN_WIDTH(CW), .STEP(g)) u_cell (
         .clock(clock), .reset(reset), .valid_in(cd_v[g]),
         .num_in(cd_num[g]), .den_in(cd_den[g]), .rem_in(cd_rem[g]),
         .valid_out(cd_v[g+1]), .num_out(cd_num[g+1]),
         .den_out(cd_den[g+1]), .rem_out(cd_rem[g+1])
      );
   end

   // Side data travels down the sqrt chain; the centre result joins it.
   logic [NSQ-1:0] cneg_ff_arr;
   side_type       side_join_w;
   always_comb begin
      side_join_w        = sq_side_ff[CNW-1];
      side_join_w.centre = sat32(cneg_ff_arr[CNW-1], 128'(cd_num[CNW]));
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NSQ; i++) begin
         if (i == 0) begin
            sq_side_ff[0]  <= s3_ff;
            cneg_ff_arr[0] <= cneg_ff;
         end else begin
            cneg_ff_arr[i] <= cneg_ff_arr[i-1];
            if (i == CNW) sq_side_ff[i] <= side_join_w;
            else sq_side_ff[i] <= sq_side_ff[i-1];
         end
      end
   end

   // Offset divider: root / |a|.
   logic [ONW:0]   od_v;
   logic [ONW-1:0] od_num [ONW+1];
   logic [CW-1:0]  od_den [ONW+1];
   logic [CW:0]    od_rem [ONW+1];
   side_type       od_side_ff [ONW];

   assign od_v[0]   = sq_v[NSQ];
   assign od_num[0] = sq_root[NSQ];
   assign od_den[0] = sq_side_ff[NSQ-1].ma;
   assign od_rem[0] = '0;
   for (g = 0; g < ONW; g++) begin : g_od
      qrs_div_cell #(.NUM_WIDTH(ONW), .DEN_WIDTH(CW), .STEP(g)) u_cell (
         .clock(clock), .reset(reset), .valid_in(od_v[g]),
         .num_in(od_num[g]), .den_in(od_den[g]), .rem_in(od_rem[g]),
         .valid_out(od_v[g+1]), .num_out(od_num[g+1]),
         .den_out(od_den[g+1]), .rem_out(od_rem[g+1])
      );
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < ONW; i++) begin
         if (i == 0) od_side_ff[0] <= sq_side_ff[NSQ-1];
         else od_side_ff[i] <= od_side_ff[i-1];
      end
   end

   // Output register.
   side_type sd_w;
   logic                 v_ff;
   logic [DISC_WIDTH-1:0] d_ff;
   logic [VAL_WIDTH-1:0] c_ff, o_ff;
   logic [KIND_WIDTH-1:0] k_ff;
   root_kind_type kind_w;
   assign sd_w = od_side_ff[ONW-1];
   always_comb begin
      if (sd_w.az) kind_w = KIND_ERROR;
      else if (sd_w.dzero) kind_w = KIND_DOUBLE;
      else if (!sd_w.dneg) kind_w = KIND_TWO;
      else if (sd_w.bzero) kind_w = KIND_IMAG;
      else kind_w = KIND_COMPLEX;
   end
   always_ff @(posedge clock) begin
      if (reset) v_ff <= 1'b0;
      else v_ff <= od_v[ONW];
      k_ff <= kind_w;
      if (sd_w.az) begin
         d_ff <= '0;
         c_ff <= '0;
         o_ff <= '0;
      end else begin
         d_ff <= sd_w.dout;
         c_ff <= sd_w.centre;
         o_ff <= sat32(sd_w.sa, 128'(od_num[ONW]));
      end
   end

   assign rsp_valid        = v_ff;
   assign rsp_discriminant = d_ff;
   assign rsp_centre_value = c_ff;
   assign rsp_offset_value = o_ff;
   assign rsp_root_kind    = k_ff;
endmodule

// ===== sv/qrs_sqrt_cell.sv =====
// One step of the restoring square root: takes two radicand bits, emits one root bit.
module qrs_sqrt_cell #(
   parameter int RAD_WIDTH = 64,
   parameter int STEP = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   valid_in,
   input  logic [RAD_WIDTH-1:0]   rad_in,
   input  logic [RAD_WIDTH/2:0]   rem_in,
   input  logic [RAD_WIDTH/2-1:0] root_in,
   output logic                   valid_out,
   output logic [RAD_WIDTH-1:0]   rad_out,
   output logic [RAD_WIDTH/2:0]   rem_out,
   output logic [RAD_WIDTH/2-1:0] root_out
);
   localparam int RW = RAD_WIDTH / 2 + 1;
   localparam int SH = RAD_WIDTH - 2 - 2 * STEP;

   logic [RW+1:0] rem_w;
   logic [RW+1:0] trial;
   logic          valid_ff;
   logic [RAD_WIDTH-1:0]   rad_ff;
   logic [RAD_WIDTH/2:0]   rem_ff, rem_in_w;
   logic [RAD_WIDTH/2-1:0] root_ff, root_in_w;

   always_comb begin
      rem_w = {rem_in, rad_in[SH +: 2]};
      trial = (RW + 2)'({root_in, 2'b01});
      if (rem_w >= trial) begin
         rem_in_w  = RW'(rem_w - trial);
         root_in_w = {root_in[RAD_WIDTH/2-2:0], 1'b1};
      end else begin
         rem_in_w  = RW'(rem_w);
         root_in_w = {root_in[RAD_WIDTH/2-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in_w;
      root_ff <= root_in_w;
   end

   assign valid_out = valid_ff;
   assign rad_out   = rad_ff;
   assign rem_out   = rem_ff;
   assign root_out  = root_ff;
endmodule

// ===== sv/qrs_div_cell.sv =====
// One step of the restoring divider: one quotient bit per cell.
module qrs_div_cell #(
   parameter int NUM_WIDTH = 64,
   parameter int DEN_WIDTH = 16,
   parameter int STEP = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 valid_in,
   input  logic [NUM_WIDTH-1:0] num_in,
   input  logic [DEN_WIDTH-1:0] den_in,
   input  logic [DEN_WIDTH:0]   rem_in,
   output logic                 valid_out,
   output logic [NUM_WIDTH-1:0] num_out,
   output logic [DEN_WIDTH-1:0] den_out,
   output logic [DEN_WIDTH:0]   rem_out
);
   localparam int BIT = NUM_WIDTH - 1 - STEP;

   logic [DEN_WIDTH+1:0] rem_w;
   logic [DEN_WIDTH:0]   rem_in_w;
   logic [NUM_WIDTH-1:0] num_in_w;
   logic                 valid_ff;
   logic [NUM_WIDTH-1:0] num_ff;
   logic [DEN_WIDTH-1:0] den_ff;
   logic [DEN_WIDTH:0]   rem_ff;

   // The quotient bit replaces the consumed numerator bit in place.
   always_comb begin
      rem_w    = {rem_in, num_in[BIT]};
      num_in_w = num_in;
      if (rem_w >= {2'b00, den_in}) begin
         rem_in_w      = (DEN_WIDTH + 1)'(rem_w - {2'b00, den_in});
         num_in_w[BIT] = 1'b1;
      end else begin
         rem_in_w      = (DEN_WIDTH + 1)'(rem_w);
         num_in_w[BIT] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
      num_ff <= num_in_w;
      den_ff <= den_in;
      rem_ff <= rem_in_w;
   end

   assign valid_out = valid_ff;
   assign num_out   = num_ff;
   assign den_out   = den_ff;
   assign rem_out   = rem_ff;
endmodule
